// ===== hw/rtl/tbpf_pkg.sv =====
`timescale 1ns / 1ps

package tbpf_pkg;

    // screen size
    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 144;

    // video memory, split into an even and an odd byte bank
    localparam int VRAM_AW    = 13;
    localparam int BANK_AW    = VRAM_AW - 1;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // tile data base for signed tile indexing
    localparam logic [VRAM_AW-1:0] SIGNED_DATA_BASE = 13'h0800;

    // lcd_control bit positions
    localparam int LCDC_BG_EN     = 0;
    localparam int LCDC_BG_MAP    = 3;
    localparam int LCDC_DATA_MODE = 4;
    localparam int LCDC_WIN_EN    = 5;
    localparam int LCDC_WIN_MAP   = 6;

    localparam logic [7:0] WINDOW_X_OFFSET = 8'd7;
    localparam logic [7:0] PALETTE_RESET   = 8'd252;

    // item operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_LCD_CONTROL = 3'd0,
        REG_SCROLL_Y    = 3'd1,
        REG_SCROLL_X    = 3'd2,
        REG_WINDOW_Y    = 3'd3,
        REG_WINDOW_X    = 3'd4,
        REG_BG_PALETTE  = 3'd5
    } tbpf_reg_idx_t;

    typedef struct packed {
        logic        op;
        logic [12:0] vram_addr;
        logic [7:0]  vram_data;
        logic [7:0]  line;
        logic [7:0]  column;
    } tbpf_req_t;

    typedef struct packed {
        logic [7:0] pixel_column;
        logic [1:0] shade;
        logic [7:0] gray;
        logic       drawn;
    } tbpf_rsp_t;

    typedef struct packed {
        logic [7:0] lcd_control;
        logic [7:0] scroll_y;
        logic [7:0] scroll_x;
        logic [7:0] window_y;
        logic [7:0] window_x;
        logic [7:0] bg_palette;
    } tbpf_cfg_t;

    // classified command: for a write addr/data are the store, for a render
    // addr is the tile map entry address
    typedef struct packed {
        logic               is_write;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         data;
        logic [2:0]         row;
        logic [2:0]         fine_x;
        logic               bg_en;
        logic [7:0]         column;
    } tbpf_cmd_t;

    function automatic logic [7:0] gray_of(input logic [1:0] shade);
        logic [7:0] g;
        unique case (shade)
            2'd0: g = 8'hFF;
            2'd1: g = 8'hCC;
            2'd2: g = 8'h77;
            2'd3: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

// ===== hw/rtl/tbpf_front.sv =====
`timescale 1ns / 1ps

module tbpf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             req_valid,
    output logic             req_ready,
    input  tbpf_pkg::tbpf_req_t req,
    output tbpf_pkg::tbpf_cfg_t cfg,
    output logic             push_valid,
    input  logic             push_ready,
    output tbpf_pkg::tbpf_cmd_t push_cmd
);
    import tbpf_pkg::*;

    tbpf_cfg_t  cfg_reg;
    tbpf_cfg_t  cfg_next;
    logic       on_screen;
    logic       window_on;
    logic       map_sel;
    logic [7:0] win_x;
    logic [7:0] ty;
    logic [7:0] tx;

    // configuration register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LCD_CONTROL: cfg_next.lcd_control = cfg_data;
                REG_SCROLL_Y:    cfg_next.scroll_y    = cfg_data;
                REG_SCROLL_X:    cfg_next.scroll_x    = cfg_data;
                REG_WINDOW_Y:    cfg_next.window_y    = cfg_data;
                REG_WINDOW_X:    cfg_next.window_x    = cfg_data;
                REG_BG_PALETTE:  cfg_next.bg_palette  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, PALETTE_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // window or scrolled background coordinates
    always_comb
    begin
        window_on = cfg_reg.lcd_control[LCDC_WIN_EN] && (cfg_reg.window_y <= req.line);
        win_x     = cfg_reg.window_x - WINDOW_X_OFFSET;
        if (window_on)
        begin
            map_sel = cfg_reg.lcd_control[LCDC_WIN_MAP];
            ty      = req.line - cfg_reg.window_y;
            tx      = req.column - win_x;
        end
        else
        begin
            map_sel = cfg_reg.lcd_control[LCDC_BG_MAP];
            ty      = req.line + cfg_reg.scroll_y;
            tx      = req.column + cfg_reg.scroll_x;
        end
    end

    // off-screen renders are dropped at transfer
    assign on_screen = ({1'b0, req.line} < 9'(SCREEN_HEIGHT))
                    && ({1'b0, req.column} < 9'(SCREEN_WIDTH));

    // classify into a queue command
    always_comb
    begin
        push_cmd.is_write = (req.op == OP_WRITE);
        push_cmd.data     = req.vram_data;
        push_cmd.row      = ty[2:0];
        push_cmd.fine_x   = tx[2:0];
        push_cmd.bg_en    = cfg_reg.lcd_control[LCDC_BG_EN];
        push_cmd.column   = req.column;
        if (req.op == OP_WRITE)
        begin
            push_cmd.addr = req.vram_addr;
        end
        else
        begin
            push_cmd.addr = {2'b11, map_sel, ty[7:3], tx[7:3]};
        end
    end

    assign push_valid = req_valid && ((req.op == OP_WRITE) || on_screen);
    assign req_ready  = push_ready;

endmodule

// ===== hw/rtl/tbpf_queue.sv =====
`timescale 1ns / 1ps

module tbpf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  tbpf_pkg::tbpf_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tbpf_pkg::tbpf_cmd_t pop_cmd
);
    import tbpf_pkg::*;

    tbpf_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/tbpf_back.sv =====
`timescale 1ns / 1ps

module tbpf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tbpf_pkg::tbpf_cfg_t cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  tbpf_pkg::tbpf_cmd_t pop_cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tbpf_pkg::tbpf_rsp_t rsp
);
    import tbpf_pkg::*;

    // even bytes in bank0, odd bytes in bank1
    logic [7:0]         bank0_mem [BANK_DEPTH];
    logic [7:0]         bank1_mem [BANK_DEPTH];
    logic [7:0]         bank0_q_reg;
    logic [7:0]         bank1_q_reg;

    logic               m_vld_reg;
    logic               m_vld_next;
    tbpf_cmd_t          m_cmd_reg;
    logic               d_vld_reg;
    logic               d_vld_next;
    tbpf_cmd_t          d_cmd_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    tbpf_rsp_t          out_reg;

    logic               d_adv;
    logic               m_adv;
    logic               pop;
    logic               wr_en;
    logic               rd_en;
    logic [BANK_AW-1:0] rd_idx;
    logic [7:0]         tile_index;
    logic [VRAM_AW-1:0] signed_base;
    logic [VRAM_AW-1:0] tile_base;
    logic [2:0]         bit_sel;
    logic [1:0]         code;
    logic [1:0]         shade;
    tbpf_rsp_t          pix;

    // stage advance; the map and tile reads share the bank ports,
    // so a new item enters only while the map stage is empty
    assign d_adv     = d_vld_reg && (!out_vld_reg || rsp_ready);
    assign m_adv     = m_vld_reg && (!d_vld_reg || d_adv);
    assign pop_ready = !m_vld_reg && (!d_vld_reg || d_adv);
    assign pop       = pop_valid && pop_ready;
    assign wr_en     = pop && pop_cmd.is_write;

    // tile data address from the fetched map entry
    always_comb
    begin
        tile_index  = m_cmd_reg.addr[0] ? bank1_q_reg : bank0_q_reg;
        signed_base = SIGNED_DATA_BASE + {1'b0, tile_index ^ 8'h80, 4'b0000};
        if (cfg.lcd_control[LCDC_DATA_MODE])
        begin
            tile_base = {1'b0, tile_index, 4'b0000};
        end
        else
        begin
            tile_base = signed_base;
        end
    end

    // read port: map entry on a render pop, tile row pair on map stage advance
    always_comb
    begin
        rd_en  = (pop && !pop_cmd.is_write) || m_adv;
        rd_idx = pop ? pop_cmd.addr[VRAM_AW-1:1]
                     : {tile_base[VRAM_AW-1:4], m_cmd_reg.row};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !pop_cmd.addr[0])
        begin
            bank0_mem[pop_cmd.addr[VRAM_AW-1:1]] <= pop_cmd.data;
        end
        if (wr_en && pop_cmd.addr[0])
        begin
            bank1_mem[pop_cmd.addr[VRAM_AW-1:1]] <= pop_cmd.data;
        end
        if (rd_en)
        begin
            bank0_q_reg <= bank0_mem[rd_idx];
            bank1_q_reg <= bank1_mem[rd_idx];
        end
    end

    // pixel from the tile row pair
    always_comb
    begin
        bit_sel          = 3'd7 - d_cmd_reg.fine_x;
        code             = {bank1_q_reg[bit_sel], bank0_q_reg[bit_sel]};
        shade            = cfg.bg_palette[{code, 1'b0} +: 2];
        pix.pixel_column = d_cmd_reg.column;
        if (d_cmd_reg.bg_en)
        begin
            pix.shade = shade;
            pix.gray  = gray_of(shade);
            pix.drawn = 1'b1;
        end
        else
        begin
            pix.shade = '0;
            pix.gray  = '0;
            pix.drawn = 1'b0;
        end
    end

    // stage valid update
    always_comb
    begin
        m_vld_next = m_vld_reg;
        d_vld_next = d_vld_reg;
        if (m_adv)
        begin
            m_vld_next = 1'b0;
        end
        if (pop && !pop_cmd.is_write)
        begin
            m_vld_next = 1'b1;
        end
        if (d_adv)
        begin
            d_vld_next = 1'b0;
        end
        if (m_adv)
        begin
            d_vld_next = 1'b1;
        end
        out_vld_next = out_vld_reg;
        if (rsp_ready)
        begin
            out_vld_next = 1'b0;
        end
        if (d_adv)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg   <= m_vld_next;
            d_vld_reg   <= d_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (pop && !pop_cmd.is_write)
        begin
            m_cmd_reg <= pop_cmd;
        end
        if (m_adv)
        begin
            d_cmd_reg <= m_cmd_reg;
        end
        if (d_adv)
        begin
            out_reg <= pix;
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

endmodule

// ===== hw/rtl/tile_background_pixel_fetch_top.sv =====
`timescale 1ns / 1ps
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------
// req       | req_valid/req_ready  | op, vram_addr, vram_data, line, column
// rsp       | rsp_valid/rsp_ready  | pixel_column, shade, gray, drawn
// cfg       | cfg_we               | cfg_index, cfg_data (write only)
//
// a write is stored as it leaves the queue; a render uses the shared video
// memory read port for the tile map entry, then the tile row pair, so an item
// leaves the queue only while the map stage is empty. reset clears control
// registers and the config registers but the palette (set to 252); video
// memory is not cleared. a two-entry queue lets the front keep taking
// transfers while the back stalls on rsp_ready.

module tile_background_pixel_fetch_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  tbpf_pkg::tbpf_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tbpf_pkg::tbpf_rsp_t rsp
);
    import tbpf_pkg::*;

    tbpf_cfg_t cfg;
    logic      push_valid;
    logic      push_ready;
    tbpf_cmd_t push_cmd;
    logic      pop_valid;
    logic      pop_ready;
    tbpf_cmd_t pop_cmd;

    // config and classification
    tbpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decoupling queue
    tbpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // memory and pixel pipeline
    tbpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== hw/rtl/tbpf_checker.sv =====
`timescale 1ns / 1ps

module tbpf_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  tbpf_pkg::tbpf_rsp_t rsp
);
    import tbpf_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // undrawn pixel carries zero shade and gray
    a_undrawn_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.drawn |-> rsp.shade == 2'd0 && rsp.gray == 8'd0)
        else $error("undrawn pixel has nonzero shade or gray");

    // gray level follows shade
    a_gray_map: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.drawn |->
            (rsp.shade == 2'd0 && rsp.gray == 8'hFF) ||
            (rsp.shade == 2'd1 && rsp.gray == 8'hCC) ||
            (rsp.shade == 2'd2 && rsp.gray == 8'h77) ||
            (rsp.shade == 2'd3 && rsp.gray == 8'h00))
        else $error("gray does not match shade");

    // only on-screen columns produce results
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> {1'b0, rsp.pixel_column} < 9'(SCREEN_WIDTH))
        else $error("result column off screen");

endmodule

bind tile_background_pixel_fetch_top tbpf_checker u_tbpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
